// ===== hdl/tidh_pkg.sv =====
// tidh_pkg: shared types and codes for the term id hash table.
// No dependencies; imported by tidh_probe and term_id_hash_table.
`timescale 1ns / 1ps
package tidh_pkg;

   localparam int KEY_W    = 31;
   localparam int TERM_W   = 9;
   localparam int CODE_W   = 32;
   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = 32;

   // item kinds (req_tuser)
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_SHRINK = 2'd2;

   // result status (rsp_tuser)
   localparam logic [1:0] STATUS_EXISTS  = 2'd0;
   localparam logic [1:0] STATUS_ADDED   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_CLEARED = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,    // zero active bank slots
      ST_IDLE,
      ST_RD,       // slot read, active bank
      ST_SLOT,     // slot data back
      ST_KEY,      // stored key back
      ST_RESP,     // load output register
      ST_GSWEEP,   // zero spare bank before rehash
      ST_WRD,      // walk old bank
      ST_WSLOT,
      ST_WKEY,
      ST_PRD,      // probe spare bank
      ST_PCHK
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } probe_ctl_type;

endpackage

// ===== hdl/tidh_ram.sv =====
// tidh_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tidh_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tidh_probe.sv =====
// tidh_probe: shared double-hash probe unit (code, step, masked position).
// Depends on tidh_pkg.
`timescale 1ns / 1ps
module tidh_probe import tidh_pkg::*; #(
   parameter int SLOT_W = 10
) (
   input  logic              clock,
   input  probe_ctl_type     ctl,
   input  logic [KEY_W-1:0]  key_in,
   input  logic [SLOT_W-1:0] mask,
   output logic [SLOT_W-1:0] pos
);

   logic [CODE_W-1:0] code_ff, code_in;
   logic [CODE_W-1:0] inc_ff, inc_in;
   logic [CODE_W-1:0] key_ext;

   assign key_ext = {{(CODE_W-KEY_W){1'b0}}, key_in};

   always_comb begin
      code_in = code_ff;
      inc_in  = inc_ff;
      if (ctl.load) begin
         code_in = key_ext;
         inc_in  = ((key_ext >> 8) + key_ext) | CODE_W'(1);
      end else if (ctl.step) begin
         code_in = code_ff + inc_ff;   // wraps at 32 bits
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      inc_ff  <= inc_in;
   end

   assign pos = code_ff[SLOT_W-1:0] & mask;

endmodule

// ===== hdl/term_id_hash_table.sv =====
// term_id_hash_table: top level, sequencer plus slot banks and key store.
// Depends on tidh_pkg, tidh_ram, tidh_probe.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | tdata: key; tuser: kind
//   rsp     | out | rsp_tvalid/tready  | tdata: term_id; tuser: status
//
// Each probe steps through ST_RD (slot read), ST_SLOT (key read) and ST_KEY
// (compare/step); an add then ends in ST_RESP. Growth zeroes the spare bank
// (one slot a cycle over the new size) and walks the old bank: ST_WRD and
// ST_WSLOT per slot, ST_WKEY, ST_PRD and ST_PCHK per id moved, and ST_PRD and
// ST_PCHK again per extra probe into the spare bank.
// Clear kinds zero the active bank, one slot a cycle over the current size.
// Reset: synchronous; after reset the first 2**InitLog2 slots (INITIAL_SLOTS
// rounded down to a power of two) are zeroed before req_tready rises.
// Stalls: req_tready is high only when idle; a result waiting in the output
// register blocks only the next result load, not the next accept.
`timescale 1ns / 1ps
module term_id_hash_table import tidh_pkg::*; #(
   parameter int MAX_SLOTS     = 1024,
   parameter int INITIAL_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [30:0] key, [31] zero
   input  logic [1:0]            req_tuser,   // [1:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [8:0] term_id, [15:9] zero
   output logic [1:0]            rsp_tuser    // [1:0] status
);

   localparam int SlotW    = $clog2(MAX_SLOTS);
   localparam int IdW      = SlotW - 1;
   localparam int LogW     = $clog2(SlotW + 1);
   localparam int InitLog2 = $clog2(INITIAL_SLOTS + 1) - 1;
   localparam int MaxIds   = MAX_SLOTS / 2;

   state_type state_ff, state_in;

   logic [LogW-1:0]  size_ff, size_in;      // log2 of table size
   logic [SlotW-1:0] count_ff, count_in;    // ids handed out
   logic             bank_ff, bank_in;      // active slot bank
   logic [SlotW-1:0] idx_ff, idx_in;        // sweep / walk index
   logic             grow_ff, grow_in;      // growth pending or running
   logic             clr_rsp_ff, clr_rsp_in;
   logic             shrink_ff, shrink_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [IdW-1:0]    pend_id_ff, pend_id_in;
   logic [1:0]        pend_st_ff, pend_st_in;
   logic [TERM_W-1:0] rsp_id_ff, rsp_id_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;

   logic [SlotW-1:0] cur_mask, new_mask, half, probe_mask, pos;
   logic [SlotW-1:0] bank0_rd, bank1_rd, act_rd, oth_rd;
   logic [SlotW-1:0] slot_rd_addr, slot_wr_addr, slot_wr_data;
   logic [SlotW-1:0] act_minus, slot_minus;
   logic             act_we, oth_we;
   logic [KEY_W-1:0] key_rd, probe_key;
   logic             key_we;
   logic [IdW-1:0]   key_rd_addr;
   logic [IdW+TERM_W-1:0] id_wide;
   logic             rsp_free;
   probe_ctl_type    pctl;

   assign cur_mask = ~({SlotW{1'b1}} << size_ff);
   assign new_mask = ~({SlotW{1'b1}} << (size_ff + LogW'(1)));
   assign half     = {{(SlotW-1){1'b0}}, 1'b1} << (size_ff - LogW'(1));
   assign probe_mask = grow_ff ? new_mask : cur_mask;

   assign act_rd     = bank_ff ? bank1_rd : bank0_rd;
   assign oth_rd     = bank_ff ? bank0_rd : bank1_rd;
   assign act_minus  = act_rd - SlotW'(1);
   assign slot_minus = slot_ff - SlotW'(1);
   assign id_wide    = {{TERM_W{1'b0}}, pend_id_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      grow_in      = grow_ff;
      clr_rsp_in   = clr_rsp_ff;
      shrink_in    = shrink_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      key_in       = key_ff;
      slot_in      = slot_ff;
      pend_id_in   = pend_id_ff;
      pend_st_in   = pend_st_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      pctl         = '0;
      probe_key    = key_rd;
      req_tready   = 1'b0;
      act_we       = 1'b0;
      oth_we       = 1'b0;
      key_we       = 1'b0;
      key_rd_addr  = act_minus[IdW-1:0];
      slot_rd_addr = pos;
      slot_wr_addr = pos;
      slot_wr_data = '0;

      case (state_ff)
         ST_CLEAR: begin
            act_we       = 1'b1;
            slot_wr_addr = idx_ff;
            if (idx_ff == cur_mask) begin
               idx_in    = '0;
               count_in  = '0;
               shrink_in = 1'b0;
               if (shrink_ff) begin
                  size_in = LogW'(InitLog2);
               end
               pend_id_in = '0;
               pend_st_in = STATUS_CLEARED;
               state_in   = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end else begin
               idx_in = idx_ff + SlotW'(1);
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            probe_key  = req_tdata[KEY_W-1:0];
            if (req_tvalid) begin
               key_in = req_tdata[KEY_W-1:0];
               case (req_tuser)
                  KIND_ADD: begin
                     pctl.load = 1'b1;
                     state_in  = ST_RD;
                  end
                  KIND_CLEAR, KIND_SHRINK: begin
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     shrink_in  = (req_tuser == KIND_SHRINK);
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     pend_id_in = '0;
                     pend_st_in = STATUS_CLEARED;
                     state_in   = ST_RESP;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (act_rd == '0) begin
               if (count_ff == SlotW'(MaxIds)) begin
                  pend_id_in = '0;
                  pend_st_in = STATUS_FULL;
               end else begin
                  key_we       = 1'b1;
                  act_we       = 1'b1;
                  slot_wr_data = count_ff + SlotW'(1);
                  pend_id_in   = count_ff[IdW-1:0];
                  pend_st_in   = STATUS_ADDED;
                  count_in     = count_ff + SlotW'(1);
                  grow_in      = (count_ff + SlotW'(1) == half)
                                 && (size_ff < LogW'(SlotW));
               end
               state_in = ST_RESP;
            end else begin
               slot_in  = act_rd;
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            if (key_rd == key_ff) begin
               pend_id_in = slot_minus[IdW-1:0];
               pend_st_in = STATUS_EXISTS;
               state_in   = ST_RESP;
            end else begin
               pctl.step = 1'b1;
               state_in  = ST_RD;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_wide[TERM_W-1:0];
               rsp_st_in    = pend_st_ff;
               clr_rsp_in   = 1'b0;
               idx_in       = '0;
               state_in     = grow_ff ? ST_GSWEEP : ST_IDLE;
            end
         end
         ST_GSWEEP: begin
            oth_we       = 1'b1;
            slot_wr_addr = idx_ff;
            if (idx_ff == new_mask) begin
               idx_in   = '0;
               state_in = ST_WRD;
            end else begin
               idx_in = idx_ff + SlotW'(1);
            end
         end
         ST_WRD: begin
            slot_rd_addr = idx_ff;
            state_in     = ST_WSLOT;
         end
         ST_WSLOT: begin
            if (act_rd == '0) begin
               if (idx_ff == cur_mask) begin
                  bank_in  = !bank_ff;
                  size_in  = size_ff + LogW'(1);
                  grow_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + SlotW'(1);
                  state_in = ST_WRD;
               end
            end else begin
               slot_in  = act_rd;
               state_in = ST_WKEY;
            end
         end
         ST_WKEY: begin
            pctl.load = 1'b1;
            state_in  = ST_PRD;
         end
         ST_PRD: begin
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            if (oth_rd == '0) begin
               oth_we       = 1'b1;
               slot_wr_data = slot_ff;
               if (idx_ff == cur_mask) begin
                  bank_in  = !bank_ff;
                  size_in  = size_ff + LogW'(1);
                  grow_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + SlotW'(1);
                  state_in = ST_WRD;
               end
            end else begin
               pctl.step = 1'b1;
               state_in  = ST_PRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= LogW'(InitLog2);
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         idx_ff       <= '0;
         grow_ff      <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         shrink_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         idx_ff       <= idx_in;
         grow_ff      <= grow_in;
         clr_rsp_ff   <= clr_rsp_in;
         shrink_ff    <= shrink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      slot_ff    <= slot_in;
      pend_id_ff <= pend_id_in;
      pend_st_ff <= pend_st_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // slot walk reads the key of the slot just fetched; adds read the same way
   tidh_probe #(.SLOT_W(SlotW)) u_probe (
      .clock  (clock),
      .ctl    (pctl),
      .key_in (probe_key),
      .mask   (probe_mask),
      .pos    (pos)
   );

   tidh_ram #(.WIDTH(SlotW), .DEPTH(MAX_SLOTS)) u_bank0 (
      .clock   (clock),
      .wr_en   (bank_ff ? oth_we : act_we),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (bank0_rd)
   );

   tidh_ram #(.WIDTH(SlotW), .DEPTH(MAX_SLOTS)) u_bank1 (
      .clock   (clock),
      .wr_en   (bank_ff ? act_we : oth_we),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (bank1_rd)
   );

   tidh_ram #(.WIDTH(KEY_W), .DEPTH(MaxIds)) u_keys (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (count_ff[IdW-1:0]),
      .wr_data (key_ff),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TERM_W){1'b0}}, rsp_id_ff};
   assign rsp_tuser  = rsp_st_ff;

endmodule
